/* rtl/joystick_bias_calibrated_position_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the joystick position block
// Implication checks on the rising clock edge, off while reset is high.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_BIAS_CALIBRATED_POSITION_ASSERT_SVH
`define JOYSTICK_BIAS_CALIBRATED_POSITION_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JBCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JBCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/jbcp_pkg.sv */
// ----------------------------------------------------------------------------
// jbcp_pkg
// Widths, register codes, defaults and shared types of the joystick block.
// ----------------------------------------------------------------------------
package jbcp_pkg;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned POS_W    = 10;
   localparam int unsigned HALF_W   = POS_W - 1;
   localparam int unsigned MAG_W    = SAMPLE_W;
   localparam int unsigned PROD_W   = MAG_W + HALF_W;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = POS_W;

   localparam int unsigned CAL_COUNT_DEFAULT  = 256;
   localparam int unsigned FULL_SCALE_DEFAULT = 1800;

   localparam logic [POS_W-1:0] TRAVEL_X_RESET = 10'd290;
   localparam logic [POS_W-1:0] TRAVEL_Y_RESET = 10'd450;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRAVEL_X = 1'b0,
      CSR_TRAVEL_Y = 1'b1
   } csr_index_type;

   // Load enables of the two payload stages inside each axis.
   typedef struct packed {
      logic load_prod;
      logic load_quot;
   } stage_en_type;

endpackage

/* rtl/jbcp_if.sv */
// ----------------------------------------------------------------------------
// jbcp_if
// Valid/ready channels for sample pairs and position results.
// ----------------------------------------------------------------------------
interface jbcp_req_if;
   import jbcp_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_x;
   logic [SAMPLE_W-1:0] sample_y;

   modport source (output valid, output sample_x, output sample_y, input ready);
   modport sink (input valid, input sample_x, input sample_y, output ready);
endinterface

interface jbcp_rsp_if;
   import jbcp_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] pos_y;
   logic [POS_W-1:0] old_x;
   logic [POS_W-1:0] old_y;
   logic             old_valid;

   modport source (output valid, output pos_x, output pos_y, output old_x,
                   output old_y, output old_valid, input ready);
   modport sink (input valid, input pos_x, input pos_y, input old_x,
                 input old_y, input old_valid, output ready);
endinterface

/* rtl/jbcp_cal.sv */
// ----------------------------------------------------------------------------
// jbcp_cal
// Sums the first CAL_COUNT sample pairs and derives the resting value of
// each axis from the average.
// ----------------------------------------------------------------------------
module jbcp_cal #(
   parameter int unsigned CAL_COUNT = jbcp_pkg::CAL_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [jbcp_pkg::SAMPLE_W-1:0] sample_x,
   input  logic [jbcp_pkg::SAMPLE_W-1:0] sample_y,
   output logic                          calibrating,
   output logic [jbcp_pkg::SAMPLE_W-1:0] rest_x,
   output logic [jbcp_pkg::SAMPLE_W-1:0] rest_y
);
   import jbcp_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAL_COUNT + 1);
   localparam int unsigned SUM_W = SAMPLE_W + $clog2(CAL_COUNT);
   // Exact quotient by a reciprocal rounded up, shifted past the dividend width.
   localparam int unsigned RS    = SUM_W + $clog2(CAL_COUNT);
   localparam int unsigned RM_W  = SUM_W + 2;
   localparam logic [63:0] RM_FULL =
      ((64'd1 << RS) + 64'(CAL_COUNT) - 64'd1) / 64'(CAL_COUNT);
   localparam logic [RM_W-1:0] RM = RM_FULL[RM_W-1:0];

   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [SUM_W-1:0]     sum_x_ff, sum_x_in;
   logic [SUM_W-1:0]     sum_y_ff, sum_y_in;
   logic                 rest_go_ff, rest_go_in;
   logic [SAMPLE_W-1:0]  rest_x_ff, rest_x_in;
   logic [SAMPLE_W-1:0]  rest_y_ff, rest_y_in;
   logic [SUM_W+RM_W-1:0] prod_x, prod_y;

   assign calibrating = (cnt_ff < CNT_W'(CAL_COUNT));

   always_comb begin
      cnt_in     = cnt_ff;
      sum_x_in   = sum_x_ff;
      sum_y_in   = sum_y_ff;
      rest_go_in = 1'b0;
      if (take) begin
         cnt_in     = cnt_ff + CNT_W'(1);
         sum_x_in   = sum_x_ff + SUM_W'(sample_x);
         sum_y_in   = sum_y_ff + SUM_W'(sample_y);
         rest_go_in = (cnt_ff == CNT_W'(CAL_COUNT - 1));
      end
   end

   // The rest values are formed the cycle after the last sum is stored.
   assign prod_x = {{RM_W{1'b0}}, sum_x_ff} * {{SUM_W{1'b0}}, RM};
   assign prod_y = {{RM_W{1'b0}}, sum_y_ff} * {{SUM_W{1'b0}}, RM};

   always_comb begin
      rest_x_in = rest_x_ff;
      rest_y_in = rest_y_ff;
      if (rest_go_ff) begin
         rest_x_in = SAMPLE_W'(prod_x >> RS);
         rest_y_in = SAMPLE_W'(prod_y >> RS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         sum_x_ff   <= '0;
         sum_y_ff   <= '0;
         rest_go_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         sum_x_ff   <= sum_x_in;
         sum_y_ff   <= sum_y_in;
         rest_go_ff <= rest_go_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_x_ff <= rest_x_in;
      rest_y_ff <= rest_y_in;
   end

   assign rest_x = rest_x_ff;
   assign rest_y = rest_y_ff;

endmodule

/* rtl/jbcp_axis.sv */
// ----------------------------------------------------------------------------
// jbcp_axis
// Maps one axis sample to a clamped position: deflection times half travel,
// divided by the full-scale value, added to half travel.
// ----------------------------------------------------------------------------
module jbcp_axis #(
   parameter int unsigned FULL_SCALE = jbcp_pkg::FULL_SCALE_DEFAULT
) (
   input  logic                          clock,
   input  jbcp_pkg::stage_en_type        stage_en,
   input  logic [jbcp_pkg::SAMPLE_W-1:0] sample,
   input  logic [jbcp_pkg::SAMPLE_W-1:0] rest,
   input  logic [jbcp_pkg::POS_W-1:0]    travel,
   output logic [jbcp_pkg::POS_W-1:0]    pos
);
   import jbcp_pkg::*;

   localparam int unsigned FS_SH = PROD_W + $clog2(FULL_SCALE);
   localparam int unsigned FM_W  = PROD_W + 2;
   localparam logic [63:0] FM_FULL =
      ((64'd1 << FS_SH) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
   localparam logic [FM_W-1:0] FM = FM_FULL[FM_W-1:0];

   logic [SAMPLE_W:0]      defl;
   logic [SAMPLE_W:0]      mag_wide;
   logic                   neg;
   logic [HALF_W-1:0]      half;
   logic [PROD_W-1:0]      prod_in;
   logic [PROD_W-1:0]      prod_ff;
   logic                   neg2_ff;
   logic [HALF_W-1:0]      half2_ff;
   logic [PROD_W+FM_W-1:0] qprod;
   logic [PROD_W-1:0]      quot_in;
   logic [PROD_W-1:0]      quot_ff;
   logic                   neg3_ff;
   logic [HALF_W-1:0]      half3_ff;
   logic [PROD_W-1:0]      half3_ext;
   logic [PROD_W:0]        hsum;

   // Work on the magnitude so the divide truncates toward zero.
   assign defl     = {1'b0, sample} - {1'b0, rest};
   assign neg      = defl[SAMPLE_W];
   assign mag_wide = neg ? (~defl + (SAMPLE_W + 1)'(1)) : defl;
   assign half     = travel[POS_W-1:1];
   assign prod_in  = {{(PROD_W - MAG_W){1'b0}}, mag_wide[MAG_W-1:0]} *
                     {{(PROD_W - HALF_W){1'b0}}, half};

   assign qprod   = {{FM_W{1'b0}}, prod_ff} * {{PROD_W{1'b0}}, FM};
   assign quot_in = PROD_W'(qprod >> FS_SH);

   always_ff @(posedge clock) begin
      if (stage_en.load_prod) begin
         prod_ff  <= prod_in;
         neg2_ff  <= neg;
         half2_ff <= half;
      end
      if (stage_en.load_quot) begin
         quot_ff  <= quot_in;
         neg3_ff  <= neg2_ff;
         half3_ff <= half2_ff;
      end
   end

   assign half3_ext = {{(PROD_W - HALF_W){1'b0}}, half3_ff};
   assign hsum      = {1'b0, half3_ext} + {1'b0, quot_ff};

   always_comb begin
      if (neg3_ff) begin
         if (quot_ff > half3_ext) begin
            pos = '0;
         end else begin
            pos = POS_W'(half3_ext - quot_ff);
         end
      end else begin
         if (hsum > (PROD_W + 1)'(travel)) begin
            pos = travel;
         end else begin
            pos = POS_W'(hsum);
         end
      end
   end

endmodule

/* rtl/joystick_bias_calibrated_position.sv */
// ----------------------------------------------------------------------------
// joystick_bias_calibrated_position
// Joystick sample pairs in, box positions out, with resting-bias calibration
// after reset and a result only when the position pair changes.
// ----------------------------------------------------------------------------
//   channel    direction  handshake          words
//   req_chan   in         valid/ready        sample_x, sample_y
//   rsp_chan   out        valid/ready        pos_x, pos_y, old_x, old_y, old_valid
//   csr_*      in         write enable only  travel_x, travel_y
//
// One word is accepted per cycle unless the pipeline is held. A mapped word
// passes the input register, the deflection multiply, the reciprocal multiply
// for the full-scale divide, then clamp and compare into the result register.
// The first CAL_COUNT words only feed the sums and give no result.
// Reset is synchronous and clears the calibration and the last position.
// A stalled result holds the pipeline only where no empty stage is left.
// ----------------------------------------------------------------------------
`include "joystick_bias_calibrated_position_assert.svh"

module joystick_bias_calibrated_position #(
   parameter int unsigned CAL_COUNT  = jbcp_pkg::CAL_COUNT_DEFAULT,
   parameter int unsigned FULL_SCALE = jbcp_pkg::FULL_SCALE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   jbcp_req_if.sink                         req_chan,
   jbcp_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [jbcp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [jbcp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import jbcp_pkg::*;

   logic [POS_W-1:0]    travel_x_ff, travel_x_in;
   logic [POS_W-1:0]    travel_y_ff, travel_y_in;
   logic                calibrating;
   logic [SAMPLE_W-1:0] rest_x, rest_y;
   logic                accept;
   logic                valid1_ff, valid1_in;
   logic                valid2_ff, valid2_in;
   logic                valid3_ff, valid3_in;
   logic [SAMPLE_W-1:0] sx1_ff, sy1_ff;
   logic                adv1, adv2, adv3;
   logic                out_can, differ, emit;
   stage_en_type        stage_en;
   logic [POS_W-1:0]    pos_x, pos_y;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_pos_x_ff, rsp_pos_y_ff, rsp_old_x_ff, rsp_old_y_ff;
   logic                rsp_old_valid_ff;
   logic [POS_W-1:0]    last_x_ff, last_x_in;
   logic [POS_W-1:0]    last_y_ff, last_y_in;
   logic                have_last_ff, have_last_in;

   // Configuration registers.
   always_comb begin
      travel_x_in = travel_x_ff;
      travel_y_in = travel_y_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TRAVEL_X: travel_x_in = csr_wdata;
            CSR_TRAVEL_Y: travel_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage advance, from the result register back to the input.
   assign out_can = !rsp_valid_ff || rsp_chan.ready;
   assign differ  = !have_last_ff || (pos_x != last_x_ff) || (pos_y != last_y_ff);
   assign emit    = valid3_ff && differ && out_can;
   assign adv3    = !valid3_ff || !differ || out_can;
   assign adv2    = !valid2_ff || adv3;
   assign adv1    = !valid1_ff || adv2;

   assign req_chan.ready = adv1;
   assign accept         = req_chan.valid && adv1;

   assign stage_en.load_prod = adv2;
   assign stage_en.load_quot = adv3;

   // Calibration words stop at the sums and never enter the pipeline.
   assign valid1_in = adv1 ? (accept && !calibrating) : valid1_ff;
   assign valid2_in = adv2 ? valid1_ff : valid2_ff;
   assign valid3_in = adv3 ? valid2_ff : valid3_ff;

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);
   assign last_x_in    = emit ? pos_x : last_x_ff;
   assign last_y_in    = emit ? pos_y : last_y_ff;
   assign have_last_in = have_last_ff || emit;

   jbcp_cal #(
      .CAL_COUNT (CAL_COUNT)
   ) u_cal (
      .clock       (clock),
      .reset       (reset),
      .take        (accept && calibrating),
      .sample_x    (req_chan.sample_x),
      .sample_y    (req_chan.sample_y),
      .calibrating (calibrating),
      .rest_x      (rest_x),
      .rest_y      (rest_y)
   );

   jbcp_axis #(
      .FULL_SCALE (FULL_SCALE)
   ) u_axis_x (
      .clock    (clock),
      .stage_en (stage_en),
      .sample   (sx1_ff),
      .rest     (rest_x),
      .travel   (travel_x_ff),
      .pos      (pos_x)
   );

   jbcp_axis #(
      .FULL_SCALE (FULL_SCALE)
   ) u_axis_y (
      .clock    (clock),
      .stage_en (stage_en),
      .sample   (sy1_ff),
      .rest     (rest_y),
      .travel   (travel_y_ff),
      .pos      (pos_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         travel_x_ff  <= TRAVEL_X_RESET;
         travel_y_ff  <= TRAVEL_Y_RESET;
         valid1_ff    <= 1'b0;
         valid2_ff    <= 1'b0;
         valid3_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         have_last_ff <= 1'b0;
      end else begin
         travel_x_ff  <= travel_x_in;
         travel_y_ff  <= travel_y_in;
         valid1_ff    <= valid1_in;
         valid2_ff    <= valid2_in;
         valid3_ff    <= valid3_in;
         rsp_valid_ff <= rsp_valid_in;
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         have_last_ff <= have_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         sx1_ff <= req_chan.sample_x;
         sy1_ff <= req_chan.sample_y;
      end
      if (emit) begin
         rsp_pos_x_ff     <= pos_x;
         rsp_pos_y_ff     <= pos_y;
         rsp_old_x_ff     <= last_x_ff;
         rsp_old_y_ff     <= last_y_ff;
         rsp_old_valid_ff <= have_last_ff;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.pos_x     = rsp_pos_x_ff;
   assign rsp_chan.pos_y     = rsp_pos_y_ff;
   assign rsp_chan.old_x     = rsp_old_x_ff;
   assign rsp_chan.old_y     = rsp_old_y_ff;
   assign rsp_chan.old_valid = rsp_old_valid_ff;

   // No result may appear before the resting values exist.
   `JBCP_ASSERT_SAME(a_no_rsp_while_cal, clock, reset, rsp_chan.valid, !calibrating, "result during calibration")

   // A result that has a predecessor must move the box.
   `JBCP_ASSERT_SAME(a_rsp_moves, clock, reset, rsp_chan.valid && rsp_chan.old_valid, (rsp_chan.pos_x != rsp_chan.old_x) || (rsp_chan.pos_y != rsp_chan.old_y), "repeated position pair")

   // The remembered pair follows every emitted word.
   `JBCP_ASSERT_NEXT(a_last_tracks, clock, reset, emit, have_last_ff && (last_x_ff == rsp_chan.pos_x) && (last_y_ff == rsp_chan.pos_y), "last position not updated")

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// Joystick position testbench
// Calibrates on a run of sample words whose average is known, walks a table
// of directed words and register writes, then sends random words under
// several travel settings. Every result word is checked field by field
// against an in-order prediction of the position mapping.
// ----------------------------------------------------------------------------
module testbench;
   import jbcp_pkg::*;

   localparam int     CAL_N        = CAL_COUNT_DEFAULT;
   localparam longint SCALE        = FULL_SCALE_DEFAULT;
   localparam int     CYCLE_LIMIT  = 300000;
   localparam int     SETTLE       = 12;
   localparam int     PHASE_WORDS  = 115;
   localparam int     IDLE_PERCENT = 38;

   // The calibration words average exactly to these resting values.
   localparam logic [SAMPLE_W-1:0] REST_X = 12'd2048;
   localparam logic [SAMPLE_W-1:0] REST_Y = 12'd2000;

   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      csr_index_type       index;
      logic [POS_W-1:0]    wdata;
      logic [SAMPLE_W-1:0] sx;
      logic [SAMPLE_W-1:0] sy;
      logic                typed;
      logic [POS_W-1:0]    ex;
      logic [POS_W-1:0]    ey;
   } stim_row_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] old_x;
      logic [POS_W-1:0] old_y;
      logic             old_valid;
   } position_word_type;

   // With travel 290/450 the centers are 145/225.
   localparam stim_row_type DIRECTED_ROWS [0:25] = '{
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    REST_X,   REST_Y,   1'b1, 10'd145,  10'd225},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    REST_X,   REST_Y,   1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd2047, 12'd1999, 1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd0,    12'd0,    1'b1, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd4095, 12'd4095, 1'b1, 10'd290,  10'd450},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd0,    12'd4095, 1'b1, 10'd0,    10'd450},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd4095, 12'd0,    1'b1, 10'd290,  10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd2049, 12'd2001, 1'b1, 10'd145,  10'd225},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd1000, 12'd3000, 1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd2500, 12'd1500, 1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd2500, 12'd1500, 1'b0, 10'd0,    10'd0},
      '{ROW_CSR,  CSR_TRAVEL_X, 10'd1023, 12'd0,    12'd0,    1'b0, 10'd0,    10'd0},
      '{ROW_CSR,  CSR_TRAVEL_Y, 10'd1023, 12'd0,    12'd0,    1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd4095, 12'd4095, 1'b1, 10'd1023, 10'd1023},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd0,    12'd0,    1'b1, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    REST_X,   REST_Y,   1'b1, 10'd511,  10'd511},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd3000, 12'd1000, 1'b0, 10'd0,    10'd0},
      '{ROW_CSR,  CSR_TRAVEL_X, 10'd0,    12'd0,    12'd0,    1'b0, 10'd0,    10'd0},
      '{ROW_CSR,  CSR_TRAVEL_Y, 10'd1,    12'd0,    12'd0,    1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd4095, 12'd0,    1'b1, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    12'd0,    12'd4095, 1'b0, 10'd0,    10'd0},
      '{ROW_CSR,  CSR_TRAVEL_X, 10'd290,  12'd0,    12'd0,    1'b0, 10'd0,    10'd0},
      '{ROW_CSR,  CSR_TRAVEL_Y, 10'd450,  12'd0,    12'd0,    1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    REST_X,   REST_Y,   1'b1, 10'd145,  10'd225},
      '{ROW_CSR,  CSR_TRAVEL_X, 10'd291,  12'd0,    12'd0,    1'b0, 10'd0,    10'd0},
      '{ROW_WORD, CSR_TRAVEL_X, 10'd0,    REST_X,   REST_Y,   1'b0, 10'd0,    10'd0}
   };

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   jbcp_req_if req_chan ();
   jbcp_rsp_if rsp_chan ();

   joystick_bias_calibrated_position i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted block state.
   int unsigned         cal_seen;
   logic [23:0]         acc_x;
   logic [23:0]         acc_y;
   logic [SAMPLE_W-1:0] rest_x;
   logic [SAMPLE_W-1:0] rest_y;
   logic [POS_W-1:0]    shown_x;
   logic [POS_W-1:0]    shown_y;
   logic                shown_valid;
   logic [POS_W-1:0]    travel_x;
   logic [POS_W-1:0]    travel_y;

   position_word_type expected_positions [$];
   int unsigned       mismatches;
   int unsigned       cycles;
   bit                no_idle;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [POS_W-1:0] axis_position(logic [SAMPLE_W-1:0] sample,
                                                     logic [SAMPLE_W-1:0] rest,
                                                     logic [POS_W-1:0] travel);
      longint defl;
      longint half;
      longint pos;
      defl = longint'(sample) - longint'(rest);
      half = longint'(travel >> 1);
      // Signed division here truncates toward zero.
      pos = half + (defl * half) / SCALE;
      if (pos < 0) pos = 0;
      if (pos > longint'(travel)) pos = longint'(travel);
      return pos[POS_W-1:0];
   endfunction

   function automatic void track_position(input logic [SAMPLE_W-1:0] sx,
                                          input logic [SAMPLE_W-1:0] sy,
                                          output bit emitted,
                                          output position_word_type w);
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      emitted = 1'b0;
      w = '0;
      if (cal_seen < CAL_N) begin
         acc_x = acc_x + 24'(sx);
         acc_y = acc_y + 24'(sy);
         cal_seen++;
         if (cal_seen >= CAL_N) begin
            rest_x = 12'(acc_x / CAL_N);
            rest_y = 12'(acc_y / CAL_N);
         end
         return;
      end
      px = axis_position(sx, rest_x, travel_x);
      py = axis_position(sy, rest_y, travel_y);
      if (shown_valid && px == shown_x && py == shown_y) return;
      emitted = 1'b1;
      w.pos_x = px;
      w.pos_y = py;
      w.old_x = shown_valid ? shown_x : '0;
      w.old_y = shown_valid ? shown_y : '0;
      w.old_valid = shown_valid;
      shown_x = px;
      shown_y = py;
      shown_valid = 1'b1;
   endfunction

   function automatic void check_field(string name, logic [POS_W-1:0] want,
                                       logic [POS_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Small jitter around the last sample in nearly half the picks, so that many
   // words map to the same position, mixed with full-range, near-rest and extreme values.
   function automatic logic [SAMPLE_W-1:0] next_sample(logic [SAMPLE_W-1:0] prev,
                                                      logic [SAMPLE_W-1:0] rest);
      int unsigned pick;
      int v;
      pick = $urandom_range(99);
      if (pick < 45) v = int'(prev) + int'($urandom_range(6)) - 3;
      else if (pick < 70) v = int'($urandom_range(4095));
      else if (pick < 90) v = int'(rest) + int'($urandom_range(100)) - 50;
      else v = $urandom_range(1) ? 4095 : 0;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[SAMPLE_W-1:0];
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input logic [SAMPLE_W-1:0] sx, input logic [SAMPLE_W-1:0] sy,
                            input logic typed, input logic [POS_W-1:0] ex,
                            input logic [POS_W-1:0] ey);
      bit emitted;
      position_word_type w;
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.sample_x <= sx;
      req_chan.sample_y <= sy;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      track_position(sx, sy, emitted, w);
      if (emitted) begin
         if (typed) begin
            w.pos_x = ex;
            w.pos_y = ey;
         end
         expected_positions.push_back(w);
      end
      @(negedge clock);
   endtask

   // Registers change only once the block has drained.
   task automatic write_travel(input csr_index_type index, input logic [POS_W-1:0] value);
      req_chan.valid <= 1'b0;
      while (expected_positions.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_TRAVEL_X) travel_x = value;
      else travel_y = value;
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready) begin
            if (expected_positions.size() == 0) begin
               $display("%0t: unexpected word pos_x=%0d pos_y=%0d old_x=%0d old_y=%0d old_valid=%0d",
                        $time, rsp_chan.pos_x, rsp_chan.pos_y, rsp_chan.old_x,
                        rsp_chan.old_y, rsp_chan.old_valid);
               mismatches++;
            end else begin
               position_word_type want;
               want = expected_positions.pop_front();
               check_field("pos_x", want.pos_x, rsp_chan.pos_x);
               check_field("pos_y", want.pos_y, rsp_chan.pos_y);
               check_field("old_x", want.old_x, rsp_chan.old_x);
               check_field("old_y", want.old_y, rsp_chan.old_y);
               check_field("old_valid", POS_W'(want.old_valid), POS_W'(rsp_chan.old_valid));
            end
         end
         @(negedge clock);
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin
      logic [SAMPLE_W-1:0] cal_x [CAL_N];
      logic [SAMPLE_W-1:0] cal_y [CAL_N];
      logic [SAMPLE_W-1:0] sx;
      logic [SAMPLE_W-1:0] sy;
      logic [POS_W-1:0]    tx;
      logic [POS_W-1:0]    ty;
      stim_row_type        row;

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_TRAVEL_X;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.sample_x = '0;
      req_chan.sample_y = '0;
      mismatches     = 0;
      no_idle        = 1'b0;
      cal_seen       = 0;
      acc_x          = '0;
      acc_y          = '0;
      rest_x         = '0;
      rest_y         = '0;
      shown_x        = '0;
      shown_y        = '0;
      shown_valid    = 1'b0;
      travel_x       = TRAVEL_X_RESET;
      travel_y       = TRAVEL_Y_RESET;

      // Calibration words come in pairs mirrored about the resting values,
      // then one word at rest and one a little above it, so the sums land
      // on an exact multiple plus a remainder that the divide drops.
      cal_x[0] = 12'd4095;
      cal_x[1] = 12'd1;
      cal_y[0] = 12'd0;
      cal_y[1] = 12'd4000;
      for (int k = 1; k < CAL_N / 2 - 1; k++) begin
         cal_x[2*k]   = REST_X + 12'($urandom_range(800)) - 12'd400;
         cal_x[2*k+1] = 12'(2 * REST_X - cal_x[2*k]);
         cal_y[2*k]   = REST_Y + 12'($urandom_range(800)) - 12'd400;
         cal_y[2*k+1] = 12'(2 * REST_Y - cal_y[2*k]);
      end
      cal_x[CAL_N-2] = REST_X;
      cal_y[CAL_N-2] = REST_Y;
      cal_x[CAL_N-1] = REST_X + 12'($urandom_range(255));
      cal_y[CAL_N-1] = REST_Y + 12'($urandom_range(255));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < CAL_N; k++)
         send_word(cal_x[k], cal_y[k], 1'b0, '0, '0);

      foreach (DIRECTED_ROWS[r]) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_CSR) write_travel(row.index, row.wdata);
         else send_word(row.sx, row.sy, row.typed, row.ex, row.ey);
      end

      sx = REST_X;
      sy = REST_Y;
      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               tx = 10'($urandom_range(1022, 2));
               ty = 10'($urandom_range(1022, 2));
            end
            1: begin
               tx = 10'd1023;
               ty = 10'd0;
            end
            2: begin
               tx = 10'd1;
               ty = 10'd1022;
            end
            3: begin
               tx = 10'($urandom_range(1023));
               ty = 10'($urandom_range(1023));
            end
            default: begin
               tx = TRAVEL_X_RESET;
               ty = TRAVEL_Y_RESET;
            end
         endcase
         write_travel(CSR_TRAVEL_X, tx);
         write_travel(CSR_TRAVEL_Y, ty);
         // One phase runs with both sides at full rate.
         no_idle = (p == 3);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            sx = next_sample(sx, rest_x);
            sy = next_sample(sy, rest_y);
            send_word(sx, sy, 1'b0, '0, '0);
         end
      end
      no_idle = 1'b0;
      req_chan.valid <= 1'b0;

      while (expected_positions.size() != 0) @(posedge clock);
      repeat (4 * SETTLE) @(posedge clock);
      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
